[sv/tbc_pkg.sv]
`default_nettype none
package tbc_pkg;

  // coordinate and product widths
  localparam int InW    = 16;
  localparam int DiffW  = InW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int CrossW = ProdW + 1;
  localparam int MagW   = CrossW - 1;

  // weight format
  localparam int WeightFracBits = 16;
  localparam int OutW           = 24;

  // divider widths: dividend 2*|num|*2^f + |den|, divisor 2*|den|
  localparam int DvdW  = MagW + WeightFracBits + 1;
  localparam int DivW  = MagW + 1;
  localparam int QuoW  = DvdW;
  localparam int SumW  = QuoW + 3;

  // one cell of the divider chain carries both weights of one item
  typedef struct packed {
    logic              vld;
    logic              deg;
    logic              neg_b;
    logic              neg_g;
    logic [DivW-1:0]   div;
    logic [DivW-1:0]   rem_b;
    logic [DivW-1:0]   rem_g;
    logic [DvdW-1:0]   dvd_b;
    logic [DvdW-1:0]   dvd_g;
    logic [QuoW-1:0]   quo_b;
    logic [QuoW-1:0]   quo_g;
  } tbc_cell_t;

endpackage
`default_nettype wire

[sv/tbc_front.sv]
`default_nettype none
module tbc_front import tbc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  vld_in,
  input  wire logic signed [InW-1:0] px,
  input  wire logic signed [InW-1:0] py,
  input  wire logic signed [InW-1:0] ax,
  input  wire logic signed [InW-1:0] ay,
  input  wire logic signed [InW-1:0] bx,
  input  wire logic signed [InW-1:0] by,
  input  wire logic signed [InW-1:0] cx,
  input  wire logic signed [InW-1:0] cy,
  output tbc_cell_t                  cell_out
);

  logic                    v1_r, v2_r;
  logic signed [DiffW-1:0] abx_r, aby_r, acx_r, acy_r, apx_r, apy_r;
  logic signed [ProdW-1:0] pa0_r, pa1_r, pb0_r, pb1_r, pg0_r, pg1_r;
  tbc_cell_t               cell_r, cell_nxt;

  logic signed [CrossW-1:0] area, nb, ng;
  logic [CrossW-1:0]        area_abs, nb_abs, ng_abs;
  logic [MagW-1:0]          ad, anb, ang;

  // valid tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_in;
      v2_r <= v1_r;
    end
  end

  // edge vectors, then products
  always_ff @(posedge clk) begin
    if (en) begin
      abx_r <= DiffW'(bx) - DiffW'(ax);
      aby_r <= DiffW'(by) - DiffW'(ay);
      acx_r <= DiffW'(cx) - DiffW'(ax);
      acy_r <= DiffW'(cy) - DiffW'(ay);
      apx_r <= DiffW'(px) - DiffW'(ax);
      apy_r <= DiffW'(py) - DiffW'(ay);
      pa0_r <= abx_r * acy_r;
      pa1_r <= aby_r * acx_r;
      pb0_r <= apx_r * acy_r;
      pb1_r <= apy_r * acx_r;
      pg0_r <= abx_r * apy_r;
      pg1_r <= aby_r * apx_r;
    end
  end

  // cross products, magnitudes and divider operands
  always_comb begin
    area     = CrossW'(pa0_r) - CrossW'(pa1_r);
    nb       = CrossW'(pb0_r) - CrossW'(pb1_r);
    ng       = CrossW'(pg0_r) - CrossW'(pg1_r);
    area_abs = area[CrossW-1] ? -area : area;
    nb_abs   = nb[CrossW-1] ? -nb : nb;
    ng_abs   = ng[CrossW-1] ? -ng : ng;
    ad       = area_abs[MagW-1:0];
    anb      = nb_abs[MagW-1:0];
    ang      = ng_abs[MagW-1:0];
    cell_nxt.vld   = v2_r;
    cell_nxt.deg   = (area == '0);
    cell_nxt.neg_b = nb[CrossW-1] ^ area[CrossW-1];
    cell_nxt.neg_g = ng[CrossW-1] ^ area[CrossW-1];
    cell_nxt.div   = {ad, 1'b0};
    cell_nxt.rem_b = '0;
    cell_nxt.rem_g = '0;
    cell_nxt.dvd_b = {anb, {WeightFracBits{1'b0}}, 1'b0} + DvdW'(ad);
    cell_nxt.dvd_g = {ang, {WeightFracBits{1'b0}}, 1'b0} + DvdW'(ad);
    cell_nxt.quo_b = '0;
    cell_nxt.quo_g = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r.vld <= cell_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r.deg   <= cell_nxt.deg;
      cell_r.neg_b <= cell_nxt.neg_b;
      cell_r.neg_g <= cell_nxt.neg_g;
      cell_r.div   <= cell_nxt.div;
      cell_r.rem_b <= cell_nxt.rem_b;
      cell_r.rem_g <= cell_nxt.rem_g;
      cell_r.dvd_b <= cell_nxt.dvd_b;
      cell_r.dvd_g <= cell_nxt.dvd_g;
      cell_r.quo_b <= cell_nxt.quo_b;
      cell_r.quo_g <= cell_nxt.quo_g;
    end
  end

  assign cell_out = cell_r;

endmodule
`default_nettype wire

[sv/tbc_div_cell.sv]
`default_nettype none
module tbc_div_cell import tbc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  tbc_cell_t cell_in,
  output tbc_cell_t cell_out
);

  tbc_cell_t       cell_r, cell_nxt;
  logic [DivW:0]   trial_b, trial_g;
  logic            take_b, take_g;

  // one restoring division step for each weight
  always_comb begin
    trial_b  = {cell_in.rem_b, cell_in.dvd_b[DvdW-1]};
    trial_g  = {cell_in.rem_g, cell_in.dvd_g[DvdW-1]};
    take_b   = trial_b >= {1'b0, cell_in.div};
    take_g   = trial_g >= {1'b0, cell_in.div};
    cell_nxt = cell_in;
    cell_nxt.rem_b = take_b ? DivW'(trial_b - {1'b0, cell_in.div}) : trial_b[DivW-1:0];
    cell_nxt.rem_g = take_g ? DivW'(trial_g - {1'b0, cell_in.div}) : trial_g[DivW-1:0];
    cell_nxt.dvd_b = {cell_in.dvd_b[DvdW-2:0], 1'b0};
    cell_nxt.dvd_g = {cell_in.dvd_g[DvdW-2:0], 1'b0};
    cell_nxt.quo_b = {cell_in.quo_b[QuoW-2:0], take_b};
    cell_nxt.quo_g = {cell_in.quo_g[QuoW-2:0], take_g};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r.vld <= cell_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r.deg   <= cell_nxt.deg;
      cell_r.neg_b <= cell_nxt.neg_b;
      cell_r.neg_g <= cell_nxt.neg_g;
      cell_r.div   <= cell_nxt.div;
      cell_r.rem_b <= cell_nxt.rem_b;
      cell_r.rem_g <= cell_nxt.rem_g;
      cell_r.dvd_b <= cell_nxt.dvd_b;
      cell_r.dvd_g <= cell_nxt.dvd_g;
      cell_r.quo_b <= cell_nxt.quo_b;
      cell_r.quo_g <= cell_nxt.quo_g;
    end
  end

  assign cell_out = cell_r;

endmodule
`default_nettype wire

[sv/triangle_barycentric_coords.sv]
// stages: 3 front stages, 51 divider cells and 1 output register lie between
//   an accepted item and its result
// throughput: one item per cycle; the pipeline holds while a result waits
// rst_n (synchronous, active low) empties every stage; no clearing pass
`default_nettype none
module triangle_barycentric_coords import tbc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic signed [InW-1:0]  in_point_x,
  input  wire logic signed [InW-1:0]  in_point_y,
  input  wire logic signed [InW-1:0]  in_vertex_a_x,
  input  wire logic signed [InW-1:0]  in_vertex_a_y,
  input  wire logic signed [InW-1:0]  in_vertex_b_x,
  input  wire logic signed [InW-1:0]  in_vertex_b_y,
  input  wire logic signed [InW-1:0]  in_vertex_c_x,
  input  wire logic signed [InW-1:0]  in_vertex_c_y,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [OutW-1:0]      out_weight_alpha,
  output logic signed [OutW-1:0]      out_weight_beta,
  output logic signed [OutW-1:0]      out_weight_gamma,
  output logic                        out_degenerate
);

  localparam logic signed [SumW-1:0] WMax = SumW'((1 <<< (OutW - 1)) - 1);
  localparam logic signed [SumW-1:0] WMin = -SumW'(1 <<< (OutW - 1));
  localparam logic signed [SumW-1:0] One  = SumW'(1 <<< WeightFracBits);

  logic      adv;
  tbc_cell_t chain [QuoW+1];

  logic                   out_valid_r;
  logic signed [OutW-1:0] alpha_r, beta_r, gamma_r;
  logic                   deg_r;
  logic signed [SumW-1:0] qb, qg, qa;
  logic signed [OutW-1:0] alpha_nxt, beta_nxt, gamma_nxt;

  function automatic logic signed [OutW-1:0] sat(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] c;
    c = (v > WMax) ? WMax : ((v < WMin) ? WMin : v);
    return c[OutW-1:0];
  endfunction

  // whole pipeline moves unless a result waits
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  tbc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .vld_in   (in_valid),
    .px       (in_point_x),
    .py       (in_point_y),
    .ax       (in_vertex_a_x),
    .ay       (in_vertex_a_y),
    .bx       (in_vertex_b_x),
    .by       (in_vertex_b_y),
    .cx       (in_vertex_c_x),
    .cy       (in_vertex_c_y),
    .cell_out (chain[0])
  );

  // divider chain, one quotient bit per cell
  for (genvar i = 0; i < QuoW; i++) begin : g_cell
    tbc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  // signs, alpha and saturation; all weights zero for a degenerate item
  always_comb begin
    qb = SumW'(chain[QuoW].quo_b);
    qg = SumW'(chain[QuoW].quo_g);
    if (chain[QuoW].neg_b) qb = -qb;
    if (chain[QuoW].neg_g) qg = -qg;
    qa = One - qb - qg;
    if (chain[QuoW].deg) begin
      alpha_nxt = '0;
      beta_nxt  = '0;
      gamma_nxt = '0;
    end else begin
      alpha_nxt = sat(qa);
      beta_nxt  = sat(qb);
      gamma_nxt = sat(qg);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain[QuoW].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      alpha_r <= alpha_nxt;
      beta_r  <= beta_nxt;
      gamma_r <= gamma_nxt;
      deg_r   <= chain[QuoW].deg;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_weight_alpha = alpha_r;
  assign out_weight_beta  = beta_r;
  assign out_weight_gamma = gamma_r;
  assign out_degenerate   = deg_r;

  // checks
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_weight_alpha == '0 && out_weight_beta == '0 && out_weight_gamma == '0))
    else $error("degenerate item with nonzero weights");

  a_stall_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import tbc_pkg::*;

  typedef struct {
    logic signed [InW-1:0] px, py, ax, ay, bx, by, cx, cy;
  } tri_item_t;

  typedef struct {
    logic signed [OutW-1:0] alpha, beta, gamma;
    logic                   deg;
  } weights_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [InW-1:0] in_point_x = '0, in_point_y = '0;
  logic signed [InW-1:0] in_vertex_a_x = '0, in_vertex_a_y = '0;
  logic signed [InW-1:0] in_vertex_b_x = '0, in_vertex_b_y = '0;
  logic signed [InW-1:0] in_vertex_c_x = '0, in_vertex_c_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OutW-1:0] out_weight_alpha, out_weight_beta, out_weight_gamma;
  logic out_degenerate;

  tri_item_t pending_tris[$];
  weights_t  expected_weights[$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        stim_loaded = 1'b0;
  bit        in_taken = 1'b0;
  bit        out_taken = 1'b0;

  localparam int CycleLimit = 400000;

  triangle_barycentric_coords u_top (.*);

  always #5 clk = ~clk;

  // round(num * 2^16 / den), ties away from zero
  function automatic longint div_round(longint num, longint den);
    longint an, ad, q;
    an = (num < 0 ? -num : num) <<< WeightFracBits;
    ad = den < 0 ? -den : den;
    q = (2 * an + ad) / (2 * ad);
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic logic signed [OutW-1:0] clamp_weight(longint v);
    if (v > 64'sd8388607) return 24'sh7fffff;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[OutW-1:0];
  endfunction

  function automatic weights_t barycentric(tri_item_t t);
    weights_t w;
    longint abx, aby, acx, acy, apx, apy, area2, b, g;
    abx = longint'(t.bx) - t.ax;  aby = longint'(t.by) - t.ay;
    acx = longint'(t.cx) - t.ax;  acy = longint'(t.cy) - t.ay;
    apx = longint'(t.px) - t.ax;  apy = longint'(t.py) - t.ay;
    area2 = abx * acy - aby * acx;
    if (area2 == 0) begin
      w.alpha = '0; w.beta = '0; w.gamma = '0; w.deg = 1'b1;
      return w;
    end
    b = div_round(apx * acy - apy * acx, area2);
    g = div_round(abx * apy - aby * apx, area2);
    w.alpha = clamp_weight((64'sd1 <<< WeightFracBits) - b - g);
    w.beta = clamp_weight(b);
    w.gamma = clamp_weight(g);
    w.deg = 1'b0;
    return w;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic tri_item_t make_tri(int px, py, ax, ay, bx, by, cx, cy);
    tri_item_t t;
    t.px = InW'(px); t.py = InW'(py); t.ax = InW'(ax); t.ay = InW'(ay);
    t.bx = InW'(bx); t.by = InW'(by); t.cx = InW'(cx); t.cy = InW'(cy);
    return t;
  endfunction

  function automatic logic signed [InW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return InW'($urandom);
      1: return InW'($urandom_range(0, 511) - 256);
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return InW'($urandom_range(0, 8191) - 4096);
    endcase
  endfunction

  // stimulus: directed corners, then random triangles
  initial begin
    tri_item_t t;
    pending_tris.push_back(make_tri(16, 16, 0, 0, 64, 0, 0, 64));
    pending_tris.push_back(make_tri(0, 0, 0, 0, 64, 0, 0, 64));
    pending_tris.push_back(make_tri(64, 0, 0, 0, 64, 0, 0, 64));
    pending_tris.push_back(make_tri(0, 64, 0, 0, 64, 0, 0, 64));
    pending_tris.push_back(make_tri(5, 5, 0, 0, 0, 0, 0, 0));
    pending_tris.push_back(make_tri(3, 3, 0, 0, 16, 16, 32, 32));
    pending_tris.push_back(make_tri(7, 9, 10, 10, 10, 10, 40, -3));
    pending_tris.push_back(make_tri(16, 16, 0, 0, 0, 64, 64, 0));
    pending_tris.push_back(make_tri(1, 0, 0, 0, 3, 0, 0, 3));
    pending_tris.push_back(make_tri(-1, 0, 0, 0, 3, 0, 0, 3));
    pending_tris.push_back(make_tri(1, 1, 0, 0, 2, 0, 0, 2));
    pending_tris.push_back(make_tri(32767, 32767, -32768, -32768, -32767, -32768,
                                    -32768, -32767));
    pending_tris.push_back(make_tri(-32768, 32767, 32767, -32768, 32766, -32768,
                                    32767, -32767));
    pending_tris.push_back(make_tri(32767, -32768, -32768, -32768, 32767, -32768,
                                    -32768, 32767));
    pending_tris.push_back(make_tri(-32768, -32768, 32767, 32767, -32768, 32767,
                                    32767, -32768));
    pending_tris.push_back(make_tri(-1, -1, -1, -1, -1, -1, -1, -1));
    pending_tris.push_back(make_tri(32767, 32767, 32767, 32767, 32767, 32767,
                                    32767, 32767));
    for (int i = 0; i < 950; i++) begin
      t.px = rand_coord(); t.py = rand_coord();
      t.ax = rand_coord(); t.ay = rand_coord();
      t.bx = rand_coord(); t.by = rand_coord();
      t.cx = rand_coord(); t.cy = rand_coord();
      // some collinear vertices for the zero-area path
      if ($urandom_range(0, 19) == 0) begin
        t.cx = t.bx; t.cy = t.by;
      end
      pending_tris.push_back(t);
    end
    stim_loaded = 1'b1;
  end

  // reset and cycle limit
  int drv_gap = 0, mon_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == 2) rst_n <= 1'b1;
    if (cycles >= CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // handshakes seen at the last rising edge
  always @(posedge clk) begin
    in_taken  <= rst_n && in_valid && in_ready;
    out_taken <= rst_n && out_valid && out_ready;
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        // hold item
      end else if (drv_gap > 0) begin
        in_valid <= 1'b0;
        drv_gap <= drv_gap - 1;
      end else if (pending_tris.size() > 0) begin
        tri_item_t t;
        t = pending_tris.pop_front();
        in_valid <= 1'b1;
        in_point_x <= t.px;    in_point_y <= t.py;
        in_vertex_a_x <= t.ax; in_vertex_a_y <= t.ay;
        in_vertex_b_x <= t.bx; in_vertex_b_y <= t.by;
        in_vertex_c_x <= t.cx; in_vertex_c_y <= t.cy;
        drv_gap <= ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 10)) : 0;
      end else begin
        in_valid <= 1'b0;
      end
      // receiver stall, drawn after each taken item
      if (mon_gap > 0) begin
        out_ready <= 1'b0;
        mon_gap <= mon_gap - 1;
      end else begin
        out_ready <= 1'b1;
        if (out_taken)
          mon_gap <= ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 10)) : 0;
      end
    end
  end

  // monitor: predict on input item, check on output item
  always @(posedge clk) begin
    tri_item_t ti;
    weights_t  w;
    if (rst_n && in_valid && in_ready) begin
      ti.px = in_point_x;    ti.py = in_point_y;
      ti.ax = in_vertex_a_x; ti.ay = in_vertex_a_y;
      ti.bx = in_vertex_b_x; ti.by = in_vertex_b_y;
      ti.cx = in_vertex_c_x; ti.cy = in_vertex_c_y;
      expected_weights.push_back(barycentric(ti));
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_weights.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        w = expected_weights.pop_front();
        if (out_weight_alpha !== w.alpha) report_mismatch("alpha", out_weight_alpha, w.alpha);
        if (out_weight_beta !== w.beta) report_mismatch("beta", out_weight_beta, w.beta);
        if (out_weight_gamma !== w.gamma) report_mismatch("gamma", out_weight_gamma, w.gamma);
        if (out_degenerate !== w.deg) report_mismatch("degenerate", out_degenerate, w.deg);
      end
    end
  end

  // end of run
  initial begin
    wait (stim_loaded && rst_n);
    wait (pending_tris.size() == 0 && !in_valid);
    wait (expected_weights.size() == 0);
    repeat (80) @(posedge clk);
    if (mismatches == 0 && expected_weights.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
